// File: rtl/core/twe_pkg.sv
// Shared types and constants of the time window event builder.
// No dependencies; used by twe_ctrl, twe_dpath and time_window_event_builder.
package twe_pkg;

   localparam int CH_W       = 3;   // width of the channel field
   localparam int MASK_W     = 8;   // width of channel mask and enable register
   localparam int TIME_W     = 32;  // pulse time and window width
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS   = 1'd1;

   localparam logic [MASK_W-1:0] CHANNEL_ENABLE_RESET = 8'hFF;
   localparam logic [TIME_W-1:0] WINDOW_TICKS_RESET   = 32'd100000;

   typedef struct packed {
      logic            take_item;  // input beat accepted this cycle
      logic            rd_go;      // issue head read for rd_ch
      logic [CH_W-1:0] rd_ch;
      logic            scan_min;   // returning head feeds the minimum search
      logic            scan_mask;  // returning head is tested against the window
      logic            min_clear;  // start a new event
      logic            out_load;   // move the event into the output register
      logic            finish;     // end of item: clear done flags if all finished
   } twe_cmd_type;

   typedef struct packed {
      logic can_build;
      logic out_free;
   } twe_status_type;

endpackage

// File: rtl/core/twe_ctrl.sv
// Sequencer of the time window event builder: accepts items and steps
// the head scans of each event. Depends on twe_pkg.
module twe_ctrl #(
   parameter int CHANNELS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  twe_pkg::twe_status_type status,
   output twe_pkg::twe_cmd_type    cmd
);

   localparam int CNT_W = $clog2(CHANNELS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_MIN    = 3'd2;
   localparam logic [2:0] ST_MASK   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             scan_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign scan_end  = (cnt_ff == CNT_W'(CHANNELS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.rd_ch = twe_pkg::CH_W'(cnt_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.can_build) begin
               cmd.min_clear = 1'b1;
               cnt_in        = '0;
               state_in      = ST_MIN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MIN: begin
            cmd.scan_min = 1'b1;
            cmd.rd_go    = !scan_end;
            if (scan_end) begin
               cnt_in   = '0;
               state_in = ST_MASK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MASK: begin
            cmd.scan_mask = 1'b1;
            cmd.rd_go     = !scan_end;
            if (scan_end) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.can_build) begin
                  cmd.min_clear = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_MIN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/core/twe_dpath.sv
// Datapath of the time window event builder: configuration registers,
// per-channel FIFOs in one pulse memory, head scans and the output register.
// Depends on twe_pkg.
module twe_dpath #(
   parameter int CHANNELS   = 8,
   parameter int FIFO_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [twe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [twe_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [twe_pkg::CH_W-1:0]         req_channel,
   input  logic                             req_pulse_valid,
   input  logic [twe_pkg::TIME_W-1:0]       req_hit_time,
   input  logic                             req_channel_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [twe_pkg::MASK_W-1:0]       rsp_event_mask,
   output logic [twe_pkg::TIME_W-1:0]       rsp_event_time,
   output logic                             rsp_overflow,
   output logic                             rsp_last_event,
   input  twe_pkg::twe_cmd_type             cmd,
   output twe_pkg::twe_status_type          status
);

   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FW    = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = SW + 1;
   localparam int DEPTH = CHANNELS * FIFO_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = twe_pkg::TIME_W;

   // configuration
   logic [twe_pkg::MASK_W-1:0] enable_ff;
   logic [TW-1:0]              window_ff;
   logic [CHANNELS-1:0]        en_eff;
   logic [TW-1:0]              win_eff;

   // per-channel FIFO control
   logic [SW-1:0]       rs_ff   [CHANNELS];
   logic [SW-1:0]       rs_in   [CHANNELS];
   logic [FW-1:0]       fill_ff [CHANNELS];
   logic [FW-1:0]       fill_in [CHANNELS];
   logic [CHANNELS-1:0] done_ff, done_in;
   logic                dropped_ff, dropped_in;

   logic [TW-1:0] mem [DEPTH];

   // head read pipeline
   logic [TW-1:0] head_ff;
   logic          rd_v_ff;
   logic [CW-1:0] rd_ch_ff;

   // event accumulation
   logic [TW-1:0]       tmin_ff, tmin_in;
   logic [CHANNELS-1:0] mask_ff, mask_in;

   logic [CW-1:0]    ch_sel, rd_c;
   logic             ch_ok, item_ok, push, drop;
   logic [SW-1:0]    rs_req, rs_issue, rs_back;
   logic [FW-1:0]    fill_req, fill_back;
   logic             en_back, live, pop_hit, min_hit, done_clear;
   logic [SUM_W-1:0] slot_sum;
   logic [SW-1:0]    wslot;
   logic [AW-1:0]    waddr, raddr;
   logic             any_pulse, blocked, all_done;

   assign en_eff  = enable_ff[CHANNELS-1:0];
   assign win_eff = (window_ff == '0) ? TW'(1) : window_ff;

   assign ch_sel  = CW'(req_channel);
   assign rd_c    = CW'(cmd.rd_ch);
   assign ch_ok   = ({1'b0, req_channel} < (twe_pkg::CH_W + 1)'(CHANNELS));

   // select per-channel state for the incoming item, the read issue and the read return
   always_comb begin
      rs_req    = '0;
      fill_req  = '0;
      rs_issue  = '0;
      rs_back   = '0;
      fill_back = '0;
      en_back   = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch_sel == CW'(c)) begin
            rs_req   = rs_ff[c];
            fill_req = fill_ff[c];
         end
         if (rd_c == CW'(c)) begin
            rs_issue = rs_ff[c];
         end
         if (rd_ch_ff == CW'(c)) begin
            rs_back   = rs_ff[c];
            fill_back = fill_ff[c];
            en_back   = en_eff[c];
         end
      end
   end

   assign item_ok  = cmd.take_item && ch_ok && en_eff[ch_sel];
   assign push     = item_ok && req_pulse_valid && (fill_req != FW'(FIFO_DEPTH));
   assign drop     = item_ok && req_pulse_valid && (fill_req == FW'(FIFO_DEPTH));

   assign slot_sum = SUM_W'(rs_req) + SUM_W'(fill_req);
   assign wslot    = (slot_sum >= SUM_W'(FIFO_DEPTH)) ?
                     SW'(slot_sum - SUM_W'(FIFO_DEPTH)) : SW'(slot_sum);
   assign waddr    = AW'(ch_sel) * AW'(FIFO_DEPTH) + AW'(wslot);
   assign raddr    = AW'(rd_c) * AW'(FIFO_DEPTH) + AW'(rs_issue);

   assign live     = rd_v_ff && en_back && (fill_back != '0);
   assign min_hit  = cmd.scan_min && live && (head_ff < tmin_ff);
   assign pop_hit  = cmd.scan_mask && live && ((head_ff - tmin_ff) < win_eff);

   always_comb begin
      any_pulse = 1'b0;
      blocked   = 1'b0;
      all_done  = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         if (en_eff[c]) begin
            if (fill_ff[c] != '0) begin
               any_pulse = 1'b1;
               all_done  = 1'b0;
            end else if (!done_ff[c]) begin
               blocked  = 1'b1;
               all_done = 1'b0;
            end
         end
      end
   end

   assign done_clear       = cmd.finish && all_done;
   assign status.can_build = any_pulse && !blocked;
   assign status.out_free  = !rsp_valid || rsp_ready;

   always_comb begin
      dropped_in = dropped_ff | drop;
      done_in    = done_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         rs_in[c]   = rs_ff[c];
         fill_in[c] = fill_ff[c];
         if (push && ch_sel == CW'(c)) begin
            fill_in[c] = fill_ff[c] + 1'b1;
         end
         if (item_ok && req_channel_end && ch_sel == CW'(c)) begin
            done_in[c] = 1'b1;
         end
         // pop the head that joined the event
         if (pop_hit && rd_ch_ff == CW'(c)) begin
            rs_in[c]   = (rs_back == SW'(FIFO_DEPTH - 1)) ? '0 : rs_back + 1'b1;
            fill_in[c] = fill_ff[c] - 1'b1;
         end
      end
      if (done_clear) begin
         done_in = '0;
      end
   end

   always_comb begin
      tmin_in = tmin_ff;
      mask_in = mask_ff;
      if (cmd.min_clear) begin
         tmin_in = '1;
         mask_in = '0;
      end else begin
         if (min_hit) begin
            tmin_in = head_ff;
         end
         if (pop_hit) begin
            mask_in = mask_ff | (CHANNELS'(1) << rd_ch_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= twe_pkg::CHANNEL_ENABLE_RESET;
         window_ff  <= twe_pkg::WINDOW_TICKS_RESET;
         done_ff    <= '0;
         dropped_ff <= 1'b0;
         rd_v_ff    <= 1'b0;
         rsp_valid  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            rs_ff[c]   <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               twe_pkg::REG_CHANNEL_ENABLE:
                  enable_ff <= twe_pkg::MASK_W'(csr_write_data);
               twe_pkg::REG_WINDOW_TICKS:
                  window_ff <= TW'(csr_write_data);
            endcase
         end
         done_ff    <= done_in;
         dropped_ff <= dropped_in;
         rd_v_ff    <= cmd.rd_go;
         for (int c = 0; c < CHANNELS; c++) begin
            rs_ff[c]   <= rs_in[c];
            fill_ff[c] <= fill_in[c];
         end
         if (cmd.out_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tmin_ff <= tmin_in;
      mask_ff <= mask_in;
      if (cmd.rd_go) begin
         rd_ch_ff <= rd_c;
      end
      if (cmd.out_load) begin
         rsp_event_mask <= twe_pkg::MASK_W'(mask_ff);
         rsp_event_time <= tmin_ff;
         rsp_overflow   <= dropped_ff;
         rsp_last_event <= !status.can_build;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[waddr] <= req_hit_time;
      end
      if (cmd.rd_go) begin
         head_ff <= mem[raddr];
      end
   end

endmodule

// File: rtl/core/time_window_event_builder.sv
// Top level of the time window event builder: sequencer plus datapath.
// Depends on twe_pkg, twe_ctrl and twe_dpath.
//
//   channel | handshake             | payload
//   req     | req_valid/req_ready   | channel, pulse_valid, hit_time, channel_end
//   rsp     | rsp_valid/rsp_ready   | event_mask, event_time, overflow, last_event
//   csr     | csr_write_enable      | csr_index, csr_write_data
//
// An input beat that builds no event passes only through the check and finish states.
// Each event makes two passes over the channel heads through the one read port
// of the pulse memory (minimum, then window test and pop), then it is emitted.
// Reset is synchronous and clears all FIFOs, done flags and the overflow flag.
// A stalled result holds in the output register; the next event waits behind it,
// while a new input beat is still taken once the current beat has finished.
module time_window_event_builder #(
   parameter int CHANNELS   = 8,
   parameter int FIFO_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [twe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [twe_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [twe_pkg::CH_W-1:0]       req_channel,
   input  logic                           req_pulse_valid,
   input  logic [twe_pkg::TIME_W-1:0]     req_hit_time,
   input  logic                           req_channel_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [twe_pkg::MASK_W-1:0]     rsp_event_mask,
   output logic [twe_pkg::TIME_W-1:0]     rsp_event_time,
   output logic                           rsp_overflow,
   output logic                           rsp_last_event
);

   twe_pkg::twe_cmd_type    cmd;
   twe_pkg::twe_status_type status;

   twe_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   twe_dpath #(
      .CHANNELS   (CHANNELS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .req_pulse_valid  (req_pulse_valid),
      .req_hit_time     (req_hit_time),
      .req_channel_end  (req_channel_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_mask   (rsp_event_mask),
      .rsp_event_time   (rsp_event_time),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_event   (rsp_last_event),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
